### src/swa_pkg.sv
// ----------------------------------------------------------------------------
// swa_pkg
// Shared constants and types of the sliding window average block.
// ----------------------------------------------------------------------------
package swa_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int LEN_BITS  = 7;
    localparam int AVG_BITS  = 24;
    localparam int SUM_BITS  = 22;
    localparam int FRAC_BITS = 8;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

### src/swa_ram.sv
// ----------------------------------------------------------------------------
// swa_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module swa_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/swa_divider.sv
// ----------------------------------------------------------------------------
// swa_divider
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module swa_divider #(
    parameter int MAG_W = 30,
    parameter int LEN_W = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [MAG_W-1:0]     dividend,
    input  logic [LEN_W-1:0]     divisor,
    output swa_pkg::div_status_t status,
    output logic [MAG_W-1:0]     quotient
);

    localparam int CNT_W = (MAG_W > 1) ? $clog2(MAG_W) : 1;

    logic             busy_reg;
    logic             busy_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [LEN_W-1:0] rem_reg;
    logic [LEN_W-1:0] rem_next;
    logic [MAG_W-1:0] quo_reg;
    logic [MAG_W-1:0] quo_next;
    logic [LEN_W-1:0] div_reg;
    logic [LEN_W-1:0] div_next;
    logic [LEN_W:0]   trial;
    logic [LEN_W:0]   diff;
    logic             fits;
    logic             last;

    assign trial = {rem_reg, quo_reg[MAG_W-1]};
    assign fits  = trial >= {1'b0, div_reg};
    assign diff  = trial - {1'b0, div_reg};
    assign last  = busy_reg && (cnt_reg == CNT_W'(MAG_W - 1));

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
            quo_next = {quo_reg[MAG_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign status.busy = busy_reg;
    assign status.done = last;
    assign quotient    = quo_reg;

endmodule

### src/sliding_window_average.sv
// ----------------------------------------------------------------------------
// sliding_window_average
// Boxcar moving average over the last window_len signed samples.
// ----------------------------------------------------------------------------
// Samples arrive on the in_valid/in_ready channel; results leave on the
// out_valid/out_ready channel as window_sum and average_q8, the average
// with 8 fraction bits, truncated toward zero. A write on window_len_we sets
// the window length (0 acts as 1, values above WINDOW_MAX act as WINDOW_MAX)
// and empties the window.
// While the window fills, in_ready stays high and a sample gives no result.
// The sample that fills the window, and each later one, starts the serial
// divider, which produces one quotient bit per cycle; each later one first
// passes an update step that swaps the oldest sample out of the sum.
// in_ready is low until the result enters the output register.
// The result waits in an output register, so a new sample is taken while
// the receiver stalls; a second result waits until the first transfer.
// Reset sets the window length to 1 and empties the window; the sample
// store needs no clearing pass.
module sliding_window_average #(
    parameter int WINDOW_MAX  = swa_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swa_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 window_len_we,
    input  logic [swa_pkg::LEN_BITS-1:0]         window_len,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [SAMPLE_BITS-1:0]        sample,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [swa_pkg::AVG_BITS-1:0]  average_q8,
    output logic signed [swa_pkg::SUM_BITS-1:0]  window_sum
);

    localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
    localparam int PTR_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_MAX);
    localparam int MAG_W  = SUM_W + swa_pkg::FRAC_BITS;
    localparam int CMP_W  = (swa_pkg::LEN_BITS > LEN_W) ? swa_pkg::LEN_BITS : LEN_W;
    localparam int AVG_XW = (MAG_W + 1 > swa_pkg::AVG_BITS) ? MAG_W + 1 : swa_pkg::AVG_BITS;
    localparam int SUM_XW = (SUM_W > swa_pkg::SUM_BITS) ? SUM_W : swa_pkg::SUM_BITS;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_UPDATE = 5'b00010,
        ST_LAUNCH = 5'b00100,
        ST_DIVIDE = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t                            state_reg;
    state_t                            state_next;
    logic [swa_pkg::LEN_BITS-1:0]      wlen_reg;
    logic [swa_pkg::LEN_BITS-1:0]      wlen_next;
    logic [PTR_W-1:0]                  ptr_reg;
    logic [PTR_W-1:0]                  ptr_next;
    logic [LEN_W-1:0]                  fill_reg;
    logic [LEN_W-1:0]                  fill_next;
    logic signed [SUM_W-1:0]           sum_reg;
    logic signed [SUM_W-1:0]           sum_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [PTR_W-1:0]                  slot_reg;
    logic [PTR_W-1:0]                  slot_next;
    logic signed [SAMPLE_BITS-1:0]     sample_reg;
    logic signed [SAMPLE_BITS-1:0]     sample_next;
    logic                              neg_reg;
    logic                              neg_next;
    logic signed [swa_pkg::AVG_BITS-1:0] avg_reg;
    logic signed [swa_pkg::AVG_BITS-1:0] avg_next;
    logic signed [swa_pkg::SUM_BITS-1:0] osum_reg;
    logic signed [swa_pkg::SUM_BITS-1:0] osum_next;

    logic [CMP_W-1:0]          cfg_ext;
    logic [LEN_W-1:0]          len;
    logic                      accept;
    logic                      filling;
    logic [PTR_W-1:0]          slot;
    logic [LEN_W-1:0]          slot_inc;
    logic signed [SUM_W-1:0]   sample_ext;
    logic signed [SUM_W-1:0]   held_ext;
    logic signed [SUM_W-1:0]   old_ext;
    logic [SAMPLE_BITS-1:0]    old_sample;
    logic [SUM_W-1:0]          sum_mag;
    logic                      ram_we;
    logic [PTR_W-1:0]          ram_waddr;
    logic [SAMPLE_BITS-1:0]    ram_wdata;
    logic                      div_start;
    swa_pkg::div_status_t      div_status;
    logic [MAG_W-1:0]          div_quo;
    logic signed [MAG_W:0]     quo_signed;
    logic signed [AVG_XW-1:0]  avg_ext;
    logic signed [SUM_XW-1:0]  sum_ext;

    always_comb
    begin
        cfg_ext = CMP_W'(wlen_reg);
        if (cfg_ext == '0)
        begin
            len = LEN_W'(1);
        end
        else if (cfg_ext > CMP_W'(WINDOW_MAX))
        begin
            len = LEN_W'(WINDOW_MAX);
        end
        else
        begin
            len = LEN_W'(cfg_ext);
        end
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign filling    = fill_reg < len;
    assign slot       = (LEN_W'(ptr_reg) >= len) ? '0 : ptr_reg;
    assign slot_inc   = LEN_W'(slot) + 1'b1;
    assign sample_ext = SUM_W'(sample);
    assign held_ext   = SUM_W'(sample_reg);
    assign old_ext    = SUM_W'($signed(old_sample));
    assign sum_mag    = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign div_start  = (state_reg == ST_LAUNCH);
    assign quo_signed = neg_reg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    assign avg_ext    = AVG_XW'(quo_signed);
    assign sum_ext    = SUM_XW'(sum_reg);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = slot;
        ram_wdata = sample;
        if (accept && filling)
        begin
            ram_we = 1'b1;
        end
        else if (state_reg == ST_UPDATE)
        begin
            ram_we    = 1'b1;
            ram_waddr = slot_reg;
            ram_wdata = sample_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        wlen_next      = wlen_reg;
        ptr_next       = ptr_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        slot_next      = slot_reg;
        sample_next    = sample_reg;
        neg_next       = neg_reg;
        avg_next       = avg_reg;
        osum_next      = osum_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    slot_next   = slot;
                    sample_next = sample;
                    ptr_next    = (slot_inc >= len) ? '0 : PTR_W'(slot_inc);
                    if (filling)
                    begin
                        sum_next  = sum_reg + sample_ext;
                        fill_next = fill_reg + 1'b1;
                        if (LEN_W'(fill_reg + 1'b1) == len)
                        begin
                            state_next = ST_LAUNCH;
                        end
                    end
                    else
                    begin
                        state_next = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE:
            begin
                sum_next   = sum_reg - old_ext + held_ext;
                state_next = ST_LAUNCH;
            end
            ST_LAUNCH:
            begin
                neg_next   = sum_reg[SUM_W-1];
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_status.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    avg_next       = avg_ext[swa_pkg::AVG_BITS-1:0];
                    osum_next      = sum_ext[swa_pkg::SUM_BITS-1:0];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (window_len_we)
        begin
            wlen_next = window_len;
            ptr_next  = '0;
            fill_next = '0;
            sum_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wlen_reg      <= swa_pkg::LEN_BITS'(1);
            ptr_reg       <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wlen_reg      <= wlen_next;
            ptr_reg       <= ptr_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        sample_reg <= sample_next;
        neg_reg    <= neg_next;
        avg_reg    <= avg_next;
        osum_reg   <= osum_next;
    end

    swa_ram #(
        .DATA_W (SAMPLE_BITS),
        .DEPTH  (WINDOW_MAX)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (slot),
        .rdata (old_sample)
    );

    swa_divider #(
        .MAG_W (MAG_W),
        .LEN_W (LEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({sum_mag, {swa_pkg::FRAC_BITS{1'b0}}}),
        .divisor  (len),
        .status   (div_status),
        .quotient (div_quo)
    );

    assign out_valid  = out_valid_reg;
    assign average_q8 = avg_reg;
    assign window_sum = osum_reg;

    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= len)
        else $error("fill count exceeds the window length");

    assert property (@(posedge clk) disable iff (!rst_n) LEN_W'(ptr_reg) < len)
        else $error("ring pointer outside the window");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == ST_DIVIDE))
        else $error("divider finished outside the divide state");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_status.busy == (state_reg == ST_DIVIDE))
        else $error("divider busy outside the divide state");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised without a finished division");

endmodule

### tb/sliding_window_average_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_average_test
// Self-checking regression of the boxcar moving average block.
// ----------------------------------------------------------------------------
// A tracker class keeps its own copy of the window and predicts the sum and
// the truncated Q8 average of every full window. Samples are driven through
// a valid/ready channel with random gaps, results are drained with random
// back-pressure, and the window length is rewritten between phases, once
// the block is idle, across the whole register range.
// ----------------------------------------------------------------------------
module sliding_window_average_test;

    localparam int WINDOW_CAP     = swa_pkg::WINDOW_MAX_DEF;
    localparam int SAMPLE_W       = swa_pkg::SAMPLE_BITS_DEF;
    localparam int SETTLE_CYCLES  = 100;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEM_TARGET    = 800;
    localparam int QUIET_AFTER    = 680;

    typedef enum int {
        STYLE_RANDOM,
        STYLE_MAX,
        STYLE_MIN,
        STYLE_NEAR_ZERO,
        STYLE_EXTREMES
    } sample_style_t;

    typedef struct {
        logic signed [swa_pkg::AVG_BITS-1:0] avg;
        logic signed [swa_pkg::SUM_BITS-1:0] total;
    } window_result_t;

    class boxcar_tracker;
        int unsigned                 eff_len;
        logic signed [SAMPLE_W-1:0]  ring [WINDOW_CAP];
        int unsigned                 wr_slot;
        int unsigned                 filled;
        longint                      running_total;
        window_result_t              expected_averages [$];
        int                          errors;

        function new();
            errors = 0;
            set_length(1);
        endfunction

        function void set_length(logic [swa_pkg::LEN_BITS-1:0] value);
            if (value == 0)
                eff_len = 1;
            else if (value > WINDOW_CAP)
                eff_len = WINDOW_CAP;
            else
                eff_len = value;
            wr_slot       = 0;
            filled        = 0;
            running_total = 0;
        endfunction

        function int pending();
            return expected_averages.size();
        endfunction

        function void take_sample(logic signed [SAMPLE_W-1:0] s);
            int unsigned    slot;
            window_result_t entry;
            slot = wr_slot;
            if (slot >= eff_len)
                slot = 0;
            if (filled < eff_len)
            begin
                ring[slot]    = s;
                running_total = running_total + s;
                filled++;
            end
            else
            begin
                running_total = running_total - ring[slot];
                ring[slot]    = s;
                running_total = running_total + s;
            end
            wr_slot = (slot + 1 >= eff_len) ? 0 : slot + 1;
            if (filled >= eff_len)
            begin
                entry.avg   = swa_pkg::AVG_BITS'((running_total * 256) /
                                                 longint'(eff_len));
                entry.total = swa_pkg::SUM_BITS'(running_total);
                expected_averages.push_back(entry);
            end
        endfunction

        task flag_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_average(logic signed [swa_pkg::AVG_BITS-1:0] got_avg,
                           logic signed [swa_pkg::SUM_BITS-1:0] got_total);
            window_result_t want;
            if (expected_averages.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected result avg=%0d sum=%0d",
                                        got_avg, got_total));
            end
            else
            begin
                want = expected_averages.pop_front();
                if (got_avg !== want.avg)
                    flag_mismatch($sformatf("average_q8 got %0d want %0d",
                                            got_avg, want.avg));
                if (got_total !== want.total)
                    flag_mismatch($sformatf("window_sum got %0d want %0d",
                                            got_total, want.total));
            end
        endtask
    endclass

    bit                                   clk;
    logic                                 rst_n;
    logic                                 window_len_we;
    logic [swa_pkg::LEN_BITS-1:0]         window_len;
    logic                                 in_valid;
    logic                                 in_ready;
    logic signed [SAMPLE_W-1:0]           sample;
    logic                                 out_valid;
    logic                                 out_ready;
    logic signed [swa_pkg::AVG_BITS-1:0]  average_q8;
    logic signed [swa_pkg::SUM_BITS-1:0]  window_sum;

    boxcar_tracker tracker;
    int            items_sent;
    int            idle_pct;
    bit            quiet;
    bit            long_hold_req;
    int            stalled_cycles;

    sliding_window_average DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .window_len_we (window_len_we),
        .window_len    (window_len),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .average_q8    (average_q8),
        .window_sum    (window_sum)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            tracker.take_sample(sample);
        if (rst_n && out_valid && out_ready)
            tracker.check_average(average_q8, window_sum);
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stalled_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready))
            stalled_cycles <= 0;
        else if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("sliding_window_average regression: fail");
            $finish;
        end
        else
            stalled_cycles <= stalled_cycles + 1;
    end

    // The receiver runs on its own, with short random stalls and one long hold.
    initial
    begin
        int n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                long_hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 99) < idle_pct)
            begin
                n = $urandom_range(1, 6);
                out_ready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic idle_input(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    task automatic send_sample(logic signed [SAMPLE_W-1:0] value);
        if (!quiet && $urandom_range(0, 99) < idle_pct)
            idle_input($urandom_range(1, 6));
        @(negedge clk);
        in_valid <= 1'b1;
        sample   <= value;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    task automatic drain_results();
        idle_input(1);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(logic [swa_pkg::LEN_BITS-1:0] value);
        drain_results();
        @(negedge clk);
        window_len_we <= 1'b1;
        window_len    <= value;
        @(posedge clk);
        tracker.set_length(value);
        @(negedge clk);
        window_len_we <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(sample_style_t style);
        int v;
        case (style)
            STYLE_MAX:       v = 32767;
            STYLE_MIN:       v = -32768;
            STYLE_NEAR_ZERO: v = int'($urandom_range(0, 16)) - 8;
            STYLE_EXTREMES:  v = ($urandom_range(0, 1) == 0) ? 32767 : -32768;
            default:         v = $urandom;
        endcase
        return SAMPLE_W'(v);
    endfunction

    task automatic run_phase(logic [swa_pkg::LEN_BITS-1:0] len_value,
                             sample_style_t style, int extra);
        int count;
        write_length(len_value);
        count = int'(tracker.eff_len) + extra;
        for (int i = 0; i < count; i++)
            send_sample(pick_sample(style));
    endtask

    initial
    begin
        int            sel;
        int            len_pick;
        sample_style_t style;
        tracker       = new();
        items_sent    = 0;
        idle_pct      = 20;
        quiet         = 1'b0;
        long_hold_req = 1'b0;
        rst_n         = 1'b0;
        window_len_we = 1'b0;
        window_len    = '0;
        in_valid      = 1'b0;
        sample        = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        write_length(1);
        send_sample(32767);
        send_sample(-32768);
        send_sample(0);
        send_sample(-1);
        send_sample(1);

        write_length(2);
        send_sample(32767);
        send_sample(32767);
        send_sample(-32768);
        send_sample(-32768);
        send_sample(-32768);

        // Small sums over three samples show truncation toward zero both ways.
        write_length(3);
        send_sample(1);
        send_sample(0);
        send_sample(0);
        send_sample(-1);
        send_sample(-1);

        write_length(0);
        send_sample(12345);
        send_sample(-12345);

        write_length(5);
        send_sample(32767);
        send_sample(-32768);
        send_sample(16384);
        send_sample(-16384);
        send_sample(1);
        send_sample(7);

        run_phase(64, STYLE_MAX, 6);
        run_phase(127, STYLE_MIN, 6);
        run_phase(65, STYLE_RANDOM, 10);

        // The receiver holds off long enough for the block to stall its input.
        write_length(1);
        long_hold_req = 1'b1;
        for (int i = 0; i < 30; i++)
            send_sample(pick_sample(STYLE_RANDOM));

        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= QUIET_AFTER)
                quiet = 1'b1;
            idle_pct = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 40);
            if ($urandom_range(0, 9) < 7)
                len_pick = $urandom_range(1, 8);
            else
                len_pick = $urandom_range(0, 127);
            sel = $urandom_range(0, 9);
            if (sel < 6)
                style = STYLE_RANDOM;
            else if (sel == 6)
                style = STYLE_MAX;
            else if (sel == 7)
                style = STYLE_MIN;
            else if (sel == 8)
                style = STYLE_NEAR_ZERO;
            else
                style = STYLE_EXTREMES;
            run_phase(swa_pkg::LEN_BITS'(len_pick), style, $urandom_range(5, 40));
        end

        drain_results();
        if (tracker.errors == 0)
            $display("sliding_window_average regression: pass");
        else
            $display("sliding_window_average regression: fail");
        $finish;
    end

endmodule
